### design/ptvc_pkg.sv
// Shared widths, constants and types of the pose tracking velocity controller.
`default_nettype none

package ptvc_pkg;

    localparam int POS_W      = 24;
    localparam int HEAD_W     = 19;
    localparam int CMD_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int ACCEL_W    = 23;
    localparam int WEIGHT_W   = 17;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int REM_W      = 28;
    localparam int CNT_W      = 5;

    localparam logic signed [24:0] PI_Q16     = 25'sd205887;
    localparam logic signed [24:0] TWO_PI_Q16 = 25'sd411775;
    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'd65536;

    localparam logic [GAIN_W-1:0]   POS_GAIN_RST    = 16'd6144;
    localparam logic [GAIN_W-1:0]   DAMP_GAIN_RST   = 16'd3277;
    localparam logic [GAIN_W-1:0]   HEAD_GAIN_RST   = 16'd8192;
    localparam logic [ACCEL_W-1:0]  ACCEL_RST       = 23'd32768;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 17'd19661;
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd1049;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_GAIN  = 3'd0,
        CFG_DAMP_GAIN = 3'd1,
        CFG_HEAD_GAIN = 3'd2,
        CFG_ACCEL     = 3'd3,
        CFG_WEIGHT    = 3'd4,
        CFG_PERIOD    = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        SD_SQRT = 1'b0,
        SD_DIV  = 1'b1
    } sd_mode_t;

    typedef struct packed {
        logic     start;
        sd_mode_t mode;
    } sd_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sd_stat_t;

endpackage

`default_nettype wire

### design/ptvc_cfg_if.sv
// Configuration write channel of the pose tracking velocity controller.
`default_nettype none

interface ptvc_cfg_if import ptvc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/ptvc_pose_if.sv
// Input channel carrying measured pose, goal pose and velocities.
`default_nettype none

interface ptvc_pose_if import ptvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  meas_x;
    logic signed [POS_W-1:0]  meas_y;
    logic signed [HEAD_W-1:0] meas_heading;
    logic signed [POS_W-1:0]  goal_x;
    logic signed [POS_W-1:0]  goal_y;
    logic signed [HEAD_W-1:0] goal_heading;
    logic signed [POS_W-1:0]  ff_vx;
    logic signed [POS_W-1:0]  ff_vy;
    logic signed [POS_W-1:0]  ff_turn_rate;
    logic signed [POS_W-1:0]  meas_vx;
    logic signed [POS_W-1:0]  meas_vy;

    modport source (output valid, output meas_x, output meas_y, output meas_heading,
                    output goal_x, output goal_y, output goal_heading, output ff_vx,
                    output ff_vy, output ff_turn_rate, output meas_vx, output meas_vy,
                    input ready);
    modport sink (input valid, input meas_x, input meas_y, input meas_heading,
                  input goal_x, input goal_y, input goal_heading, input ff_vx,
                  input ff_vy, input ff_turn_rate, input meas_vx, input meas_vy,
                  output ready);
endinterface

`default_nettype wire

### design/ptvc_cmd_if.sv
// Output channel carrying the velocity command.
`default_nettype none

interface ptvc_cmd_if import ptvc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] cmd_vx;
    logic signed [CMD_W-1:0] cmd_vy;
    logic signed [CMD_W-1:0] cmd_turn_rate;
    logic                    accel_clipped;

    modport source (output valid, output cmd_vx, output cmd_vy, output cmd_turn_rate,
                    output accel_clipped, input ready);
    modport sink (input valid, input cmd_vx, input cmd_vy, input cmd_turn_rate,
                  input accel_clipped, output ready);
endinterface

`default_nettype wire

### design/ptvc_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module ptvc_mul import ptvc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### design/ptvc_sqdiv.sv
// Shift and subtract unit for the integer square root and the unsigned division.
`default_nettype none

module ptvc_sqdiv import ptvc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sd_req_t           req,
    input  logic [SQ_W-1:0]   num,
    input  logic [ROOT_W-1:0] den,
    output sd_stat_t          stat,
    output logic [ROOT_W-1:0] result
);

    sd_mode_t          mode_reg;
    logic [SQ_W-1:0]   sh_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] res_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // The root mode brings down two radicand bits per step, the divide mode one dividend bit.
    always_comb
    begin
        if (mode_reg == SD_SQRT)
        begin
            cand  = {rem_reg[REM_W-3:0], sh_reg[SQ_W-1:SQ_W-2]};
            trial = {1'b0, res_reg, 2'b01};
        end
        else
        begin
            cand  = {rem_reg[REM_W-2:0], sh_reg[SQ_W-1]};
            trial = {3'b000, den_reg};
        end
        ge = (cand >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= SD_SQRT;
            sh_reg   <= '0;
            rem_reg  <= '0;
            res_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                done_reg <= 1'b0;
                mode_reg <= req.mode;
                den_reg  <= den;
                res_reg  <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
                if (req.mode == SD_SQRT)
                begin
                    sh_reg  <= num;
                    rem_reg <= '0;
                end
                else
                begin
                    sh_reg  <= {num[ROOT_W-1:0], {(SQ_W-ROOT_W){1'b0}}};
                    rem_reg <= {3'b000, num[SQ_W-1:ROOT_W]};
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? (cand - trial) : cand;
                res_reg  <= {res_reg[ROOT_W-2:0], ge};
                sh_reg   <= (mode_reg == SD_SQRT) ? {sh_reg[SQ_W-3:0], 2'b00}
                                                  : {sh_reg[SQ_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

### design/pose_tracking_velocity_controller.sv
// Pose tracking velocity controller: filtered pose PD feedback with acceleration limit.
// The input is not ready again until the command is written to the output register, so an
// item is only taken when the last one is through, and an output stall holds the flow; the
// shared multiplier and the 25-step root and divide unit (one root, two divisions when
// clipping) are used in turn by the sequencer.
// Reset (rst_n, asynchronous, active low) restores default gains and clears all state.
`default_nettype none

module pose_tracking_velocity_controller import ptvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ptvc_cfg_if.sink    cfg,
    ptvc_pose_if.sink   pose_in,
    ptvc_cmd_if.source  cmd_out
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_FX, ST_FY, ST_FH, ST_PX, ST_DX, ST_PY, ST_DY, ST_HD, ST_LM,
        ST_SX, ST_SY, ST_LL, ST_CMP, ST_ROOT, ST_QX, ST_WX, ST_QY, ST_WY, ST_DONE
    } state_t;

    state_t                   state_reg;

    logic [GAIN_W-1:0]        pos_gain_reg;
    logic [GAIN_W-1:0]        damp_gain_reg;
    logic [GAIN_W-1:0]        head_gain_reg;
    logic [ACCEL_W-1:0]       accel_reg;
    logic [WEIGHT_W-1:0]      weight_reg;
    logic [PERIOD_W-1:0]      period_reg;

    logic signed [POS_W-1:0]  meas_reg [3];
    logic signed [POS_W-1:0]  goal_reg [3];
    logic signed [POS_W-1:0]  ff_reg [3];
    logic signed [POS_W-1:0]  mv_reg [2];
    logic signed [POS_W-1:0]  s_reg [3];
    logic signed [CMD_W-1:0]  prev_reg [3];
    logic signed [CMD_W-1:0]  cmd_reg [3];
    logic                     seeded_reg;
    logic                     clipped_reg;
    logic signed [33:0]       acc_reg;
    logic [23:0]              lim_reg;
    logic [SQ_W-1:0]          ss_reg;
    logic signed [24:0]       dx_reg;
    logic signed [24:0]       dy_reg;
    logic [ROOT_W-1:0]        n_reg;

    logic                     out_valid_reg;
    logic signed [CMD_W-1:0]  out_vx_reg;
    logic signed [CMD_W-1:0]  out_vy_reg;
    logic signed [CMD_W-1:0]  out_turn_reg;
    logic                     out_clip_reg;

    logic [WEIGHT_W-1:0]      w_eff;
    logic signed [POS_W-1:0]  base [3];
    logic signed [24:0]       diff [3];
    logic signed [24:0]       pe [2];
    logic signed [24:0]       ve [2];
    logic signed [24:0]       he_raw;
    logic signed [24:0]       he;
    logic signed [24:0]       dx_now;
    logic signed [24:0]       dy_now;
    logic [24:0]              mag_x;
    logic [24:0]              mag_y;
    logic                     prev_nz;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] p_rs16;
    logic signed [PROD_W-1:0] p_rs12;
    logic signed [33:0]       step_x;
    logic signed [33:0]       step_y;
    logic                     out_free;

    sd_req_t                  sd_req;
    sd_stat_t                 sd_stat;
    logic [SQ_W-1:0]          sd_num;
    logic [ROOT_W-1:0]        sd_res;

    function automatic logic signed [CMD_W-1:0] sat24(input logic signed [33:0] v);
        if (v > 34'sd8388607)
            return 24'sh7FFFFF;
        else if (v < -34'sd8388608)
            return 24'sh800000;
        else
            return v[CMD_W-1:0];
    endfunction

    ptvc_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    ptvc_sqdiv u_sqdiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sd_req),
        .num    (sd_num),
        .den    (n_reg),
        .stat   (sd_stat),
        .result (sd_res)
    );

    assign cfg.ready     = 1'b1;
    assign pose_in.ready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || cmd_out.ready;

    assign cmd_out.valid         = out_valid_reg;
    assign cmd_out.cmd_vx        = out_vx_reg;
    assign cmd_out.cmd_vy        = out_vy_reg;
    assign cmd_out.cmd_turn_rate = out_turn_reg;
    assign cmd_out.accel_clipped = out_clip_reg;

    // Datapath terms feeding the shared multiplier.
    always_comb
    begin
        w_eff = (weight_reg > ONE_Q16) ? ONE_Q16 : weight_reg;
        for (int i = 0; i < 3; i++)
        begin
            base[i] = seeded_reg ? s_reg[i] : meas_reg[i];
            diff[i] = {meas_reg[i][POS_W-1], meas_reg[i]} - {base[i][POS_W-1], base[i]};
        end
        for (int i = 0; i < 2; i++)
        begin
            pe[i] = {goal_reg[i][POS_W-1], goal_reg[i]} - {s_reg[i][POS_W-1], s_reg[i]};
            ve[i] = {ff_reg[i][POS_W-1], ff_reg[i]} - {mv_reg[i][POS_W-1], mv_reg[i]};
        end
        he_raw = {goal_reg[2][POS_W-1], goal_reg[2]} - {s_reg[2][POS_W-1], s_reg[2]};
        if (he_raw > PI_Q16)
            he = he_raw - TWO_PI_Q16;
        else if (he_raw < -PI_Q16)
            he = he_raw + TWO_PI_Q16;
        else
            he = he_raw;
        dx_now  = {cmd_reg[0][CMD_W-1], cmd_reg[0]} - {prev_reg[0][CMD_W-1], prev_reg[0]};
        dy_now  = {cmd_reg[1][CMD_W-1], cmd_reg[1]} - {prev_reg[1][CMD_W-1], prev_reg[1]};
        mag_x   = dx_reg[24] ? 25'(-dx_reg) : 25'(dx_reg);
        mag_y   = dy_reg[24] ? 25'(-dy_reg) : 25'(dy_reg);
        prev_nz = (prev_reg[0] != '0) || (prev_reg[1] != '0) || (prev_reg[2] != '0);
        p_rs16  = (mul_p + PROD_W'(32768)) >>> 16;
        p_rs12  = (mul_p + PROD_W'(2048)) >>> 12;
        step_x  = dx_reg[24] ? ({{10{prev_reg[0][CMD_W-1]}}, prev_reg[0]} - {9'd0, sd_res})
                             : ({{10{prev_reg[0][CMD_W-1]}}, prev_reg[0]} + {9'd0, sd_res});
        step_y  = dy_reg[24] ? ({{10{prev_reg[1][CMD_W-1]}}, prev_reg[1]} - {9'd0, sd_res})
                             : ({{10{prev_reg[1][CMD_W-1]}}, prev_reg[1]} + {9'd0, sd_res});
    end

    // Operand selection per sequencer step; the product is used one step later.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_FX:   begin mul_a = {9'd0, w_eff};  mul_b = {diff[0][24], diff[0]}; end
            ST_FY:   begin mul_a = {9'd0, w_eff};  mul_b = {diff[1][24], diff[1]}; end
            ST_FH:   begin mul_a = {9'd0, w_eff};  mul_b = {diff[2][24], diff[2]}; end
            ST_PX:   begin mul_a = {10'd0, pos_gain_reg};  mul_b = {pe[0][24], pe[0]}; end
            ST_DX:   begin mul_a = {10'd0, damp_gain_reg}; mul_b = {ve[0][24], ve[0]}; end
            ST_PY:   begin mul_a = {10'd0, pos_gain_reg};  mul_b = {pe[1][24], pe[1]}; end
            ST_DY:   begin mul_a = {10'd0, damp_gain_reg}; mul_b = {ve[1][24], ve[1]}; end
            ST_HD:   begin mul_a = {10'd0, head_gain_reg}; mul_b = {he[24], he}; end
            ST_LM:   begin mul_a = {3'd0, accel_reg};  mul_b = {10'd0, period_reg}; end
            ST_SX:   begin mul_a = {dx_now[24], dx_now}; mul_b = {dx_now[24], dx_now}; end
            ST_SY:   begin mul_a = {dy_now[24], dy_now}; mul_b = {dy_now[24], dy_now}; end
            ST_LL:   begin mul_a = {2'd0, lim_reg}; mul_b = {2'd0, lim_reg}; end
            ST_ROOT: begin mul_a = {1'b0, mag_x};   mul_b = {2'd0, lim_reg}; end
            ST_WX:   begin mul_a = {1'b0, mag_y};   mul_b = {2'd0, lim_reg}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        sd_req.start = 1'b0;
        sd_req.mode  = SD_SQRT;
        sd_num       = ss_reg;
        case (state_reg)
            ST_CMP:
            begin
                sd_req.start = prev_nz && (ss_reg > mul_p[SQ_W-1:0]);
            end
            ST_QX, ST_QY:
            begin
                sd_req.start = 1'b1;
                sd_req.mode  = SD_DIV;
                sd_num       = mul_p[SQ_W-1:0] + {26'd0, n_reg[ROOT_W-1:1]};
            end
            default:
            begin
                sd_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_gain_reg  <= POS_GAIN_RST;
            damp_gain_reg <= DAMP_GAIN_RST;
            head_gain_reg <= HEAD_GAIN_RST;
            accel_reg     <= ACCEL_RST;
            weight_reg    <= WEIGHT_RST;
            period_reg    <= PERIOD_RST;
            for (int i = 0; i < 3; i++)
            begin
                meas_reg[i] <= '0;
                goal_reg[i] <= '0;
                ff_reg[i]   <= '0;
                s_reg[i]    <= '0;
                prev_reg[i] <= '0;
                cmd_reg[i]  <= '0;
            end
            mv_reg[0]     <= '0;
            mv_reg[1]     <= '0;
            seeded_reg    <= 1'b0;
            clipped_reg   <= 1'b0;
            acc_reg       <= '0;
            lim_reg       <= '0;
            ss_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_vx_reg    <= '0;
            out_vy_reg    <= '0;
            out_turn_reg  <= '0;
            out_clip_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_POS_GAIN:  pos_gain_reg  <= cfg.data[GAIN_W-1:0];
                    CFG_DAMP_GAIN: damp_gain_reg <= cfg.data[GAIN_W-1:0];
                    CFG_HEAD_GAIN: head_gain_reg <= cfg.data[GAIN_W-1:0];
                    CFG_ACCEL:     accel_reg     <= cfg.data[ACCEL_W-1:0];
                    CFG_WEIGHT:    weight_reg    <= cfg.data[WEIGHT_W-1:0];
                    CFG_PERIOD:    period_reg    <= cfg.data[PERIOD_W-1:0];
                    default:       ;
                endcase
            end

            // In the done step a taken command is replaced by the next one below.
            if (out_valid_reg && cmd_out.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (pose_in.valid)
                    begin
                        meas_reg[0] <= pose_in.meas_x;
                        meas_reg[1] <= pose_in.meas_y;
                        meas_reg[2] <= POS_W'(pose_in.meas_heading);
                        goal_reg[0] <= pose_in.goal_x;
                        goal_reg[1] <= pose_in.goal_y;
                        goal_reg[2] <= POS_W'(pose_in.goal_heading);
                        ff_reg[0]   <= pose_in.ff_vx;
                        ff_reg[1]   <= pose_in.ff_vy;
                        ff_reg[2]   <= pose_in.ff_turn_rate;
                        mv_reg[0]   <= pose_in.meas_vx;
                        mv_reg[1]   <= pose_in.meas_vy;
                        state_reg   <= ST_FX;
                    end
                end
                ST_FX: state_reg <= ST_FY;
                ST_FY:
                begin
                    s_reg[0]  <= base[0] + p_rs16[POS_W-1:0];
                    state_reg <= ST_FH;
                end
                ST_FH:
                begin
                    s_reg[1]  <= base[1] + p_rs16[POS_W-1:0];
                    state_reg <= ST_PX;
                end
                ST_PX:
                begin
                    s_reg[2]   <= base[2] + p_rs16[POS_W-1:0];
                    seeded_reg <= 1'b1;
                    state_reg  <= ST_DX;
                end
                ST_DX:
                begin
                    acc_reg   <= {{10{ff_reg[0][POS_W-1]}}, ff_reg[0]} + p_rs12[33:0];
                    state_reg <= ST_PY;
                end
                ST_PY:
                begin
                    cmd_reg[0] <= sat24(acc_reg - p_rs12[33:0]);
                    state_reg  <= ST_DY;
                end
                ST_DY:
                begin
                    acc_reg   <= {{10{ff_reg[1][POS_W-1]}}, ff_reg[1]} + p_rs12[33:0];
                    state_reg <= ST_HD;
                end
                ST_HD:
                begin
                    cmd_reg[1] <= sat24(acc_reg - p_rs12[33:0]);
                    state_reg  <= ST_LM;
                end
                ST_LM:
                begin
                    cmd_reg[2] <= sat24({{10{ff_reg[2][POS_W-1]}}, ff_reg[2]} + p_rs12[33:0]);
                    state_reg  <= ST_SX;
                end
                ST_SX:
                begin
                    lim_reg   <= p_rs16[23:0];
                    dx_reg    <= dx_now;
                    state_reg <= ST_SY;
                end
                ST_SY:
                begin
                    ss_reg    <= mul_p[SQ_W-1:0];
                    dy_reg    <= dy_now;
                    state_reg <= ST_LL;
                end
                ST_LL:
                begin
                    ss_reg    <= ss_reg + mul_p[SQ_W-1:0];
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    clipped_reg <= sd_req.start;
                    state_reg   <= sd_req.start ? ST_ROOT : ST_DONE;
                end
                ST_ROOT:
                begin
                    if (sd_stat.done)
                    begin
                        n_reg     <= sd_res;
                        state_reg <= ST_QX;
                    end
                end
                ST_QX: state_reg <= ST_WX;
                ST_WX:
                begin
                    if (sd_stat.done)
                    begin
                        cmd_reg[0] <= sat24(step_x);
                        state_reg  <= ST_QY;
                    end
                end
                ST_QY: state_reg <= ST_WY;
                ST_WY:
                begin
                    if (sd_stat.done)
                    begin
                        cmd_reg[1] <= sat24(step_y);
                        state_reg  <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // The result waits here until the output register is free.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_vx_reg    <= cmd_reg[0];
                        out_vy_reg    <= cmd_reg[1];
                        out_turn_reg  <= cmd_reg[2];
                        out_clip_reg  <= clipped_reg;
                        for (int i = 0; i < 3; i++)
                            prev_reg[i] <= cmd_reg[i];
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pose_in.ready |-> !sd_stat.busy)
        else $error("input ready while root/divide unit is busy");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (pose_in.valid && pose_in.ready) |=> !pose_in.ready)
        else $error("input ready right after a transfer");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sd_stat.done |-> (state_reg == ST_ROOT || state_reg == ST_WX || state_reg == ST_WY))
        else $error("root/divide result outside a wait step");

    a_seeded_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_out.valid |-> seeded_reg)
        else $error("command delivered before the filter was seeded");
`endif

endmodule

`default_nettype wire

### test/tb_ptvc_pkg.sv
// Shared types for the pose tracking velocity controller testbench.
`default_nettype none

package tb_ptvc_pkg;
    import ptvc_pkg::*;

    typedef struct {
        logic signed [POS_W-1:0]  meas_x;
        logic signed [POS_W-1:0]  meas_y;
        logic signed [HEAD_W-1:0] meas_heading;
        logic signed [POS_W-1:0]  goal_x;
        logic signed [POS_W-1:0]  goal_y;
        logic signed [HEAD_W-1:0] goal_heading;
        logic signed [POS_W-1:0]  ff_vx;
        logic signed [POS_W-1:0]  ff_vy;
        logic signed [POS_W-1:0]  ff_turn_rate;
        logic signed [POS_W-1:0]  meas_vx;
        logic signed [POS_W-1:0]  meas_vy;
    } pose_item_t;

    typedef struct {
        logic signed [CMD_W-1:0] cmd_vx;
        logic signed [CMD_W-1:0] cmd_vy;
        logic signed [CMD_W-1:0] cmd_turn_rate;
        logic                    accel_clipped;
    } velocity_cmd_t;
endpackage

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench of the pose tracking velocity controller.
`default_nettype none

module tb_top;
    import ptvc_pkg::*;
    import tb_ptvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 800;
    localparam int SETTLE_CYCLES = 200;
    localparam int PEND_DEPTH = 16;
    localparam int VEC_ROWS = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptvc_cfg_if  cfg();
    ptvc_pose_if pose_in();
    ptvc_cmd_if  cmd_out();

    pose_tracking_velocity_controller dut (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .pose_in(pose_in), .cmd_out(cmd_out)
    );

    always #5 clk = ~clk;

    // Predictor copy of the controller registers and state.
    longint pos_gain, damp_gain, head_gain, accel_lim, weight, period;
    longint filt_pose[3];
    bit     filt_seeded;
    longint last_cmd[3];

    // Expected commands in transfer order, as a ring with write and read counts.
    velocity_cmd_t pending_cmds [PEND_DEPTH];
    int  pend_wr = 0;
    int  pend_rd = 0;
    int  error_count = 0;
    int  idle_cycles = 0;
    bit  rx_stall_on = 1'b1;

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint floor_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint scale_step(longint delta, longint lim, longint n);
        longint mag, q;
        mag = (delta < 0) ? -delta : delta;
        q = (mag * lim + n / 2) / n;
        return (delta < 0) ? -q : q;
    endfunction

    task automatic load_defaults();
        pos_gain = POS_GAIN_RST;
        damp_gain = DAMP_GAIN_RST;
        head_gain = HEAD_GAIN_RST;
        accel_lim = ACCEL_RST;
        weight = WEIGHT_RST;
        period = PERIOD_RST;
        filt_seeded = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            filt_pose[i] = 0;
            last_cmd[i] = 0;
        end
    endtask

    function automatic velocity_cmd_t predict_command(pose_item_t p);
        longint meas[3], goal[3], ff[3], mv[2], cmd[3];
        longint w, pe, ve, he, dx, dy, lim, n;
        longint unsigned ss;
        velocity_cmd_t r;
        meas = '{p.meas_x, p.meas_y, p.meas_heading};
        goal = '{p.goal_x, p.goal_y, p.goal_heading};
        ff = '{p.ff_vx, p.ff_vy, p.ff_turn_rate};
        mv = '{p.meas_vx, p.meas_vy};
        w = (weight > 65536) ? 65536 : weight;
        r.accel_clipped = 1'b0;
        if (!filt_seeded)
        begin
            for (int i = 0; i < 3; i++) filt_pose[i] = meas[i];
            filt_seeded = 1'b1;
        end
        for (int i = 0; i < 3; i++)
            filt_pose[i] = round_sh(w * meas[i] + (65536 - w) * filt_pose[i], 16);
        for (int i = 0; i < 2; i++)
        begin
            pe = goal[i] - filt_pose[i];
            ve = ff[i] - mv[i];
            cmd[i] = clamp24(ff[i] + round_sh(pos_gain * pe, 12) - round_sh(damp_gain * ve, 12));
        end
        he = goal[2] - filt_pose[2];
        if (he > 205887) he = he - 411775;
        else if (he < -205887) he = he + 411775;
        cmd[2] = clamp24(ff[2] + round_sh(head_gain * he, 12));
        if (last_cmd[0] != 0 || last_cmd[1] != 0 || last_cmd[2] != 0)
        begin
            dx = cmd[0] - last_cmd[0];
            dy = cmd[1] - last_cmd[1];
            lim = round_sh(accel_lim * period, 16);
            ss = longint'(dx * dx) + longint'(dy * dy);
            if (ss > longint'(lim * lim))
            begin
                n = floor_root(ss);
                cmd[0] = clamp24(last_cmd[0] + scale_step(dx, lim, n));
                cmd[1] = clamp24(last_cmd[1] + scale_step(dy, lim, n));
                r.accel_clipped = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) last_cmd[i] = cmd[i];
        r.cmd_vx = cmd[0][CMD_W-1:0];
        r.cmd_vy = cmd[1][CMD_W-1:0];
        r.cmd_turn_rate = cmd[2][CMD_W-1:0];
        return r;
    endfunction

    task automatic write_reg(cfg_idx_t idx, longint value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_POS_GAIN:  pos_gain = value & 16'hFFFF;
            CFG_DAMP_GAIN: damp_gain = value & 16'hFFFF;
            CFG_HEAD_GAIN: head_gain = value & 16'hFFFF;
            CFG_ACCEL:     accel_lim = value & 23'h7FFFFF;
            CFG_WEIGHT:    weight = value & 17'h1FFFF;
            CFG_PERIOD:    period = value & 16'hFFFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Sends one item and queues its expected command: the given one if has_fixed, else the predicted one.
    task automatic send_pose(pose_item_t p, bit has_fixed, velocity_cmd_t fixed_cmd);
        velocity_cmd_t e;
        pose_in.valid <= 1'b1;
        pose_in.meas_x <= p.meas_x;
        pose_in.meas_y <= p.meas_y;
        pose_in.meas_heading <= p.meas_heading;
        pose_in.goal_x <= p.goal_x;
        pose_in.goal_y <= p.goal_y;
        pose_in.goal_heading <= p.goal_heading;
        pose_in.ff_vx <= p.ff_vx;
        pose_in.ff_vy <= p.ff_vy;
        pose_in.ff_turn_rate <= p.ff_turn_rate;
        pose_in.meas_vx <= p.meas_vx;
        pose_in.meas_vy <= p.meas_vy;
        do @(posedge clk); while (!pose_in.ready);
        e = predict_command(p);
        if (has_fixed) e = fixed_cmd;
        pending_cmds[pend_wr % PEND_DEPTH] = e;
        pend_wr++;
    endtask

    task automatic wait_drained();
        while (pend_wr != pend_rd) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return POS_W'($urandom_range(0, 2000) - 1000);
            3: return POS_W'($urandom_range(0, 400000) - 200000);
            default: return POS_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [HEAD_W-1:0] rand_heading();
        case ($urandom_range(0, 4))
            0: return HEAD_W'(205887);
            1: return HEAD_W'(-205887);
            default: return HEAD_W'($urandom_range(0, 411774) - 205887);
        endcase
    endfunction

    function automatic pose_item_t rand_pose(bit wild);
        pose_item_t p;
        p.meas_heading = rand_heading();
        p.goal_heading = rand_heading();
        if (wild)
        begin
            p.meas_x = rand_pos(); p.meas_y = rand_pos();
            p.goal_x = rand_pos(); p.goal_y = rand_pos();
            p.ff_vx = rand_pos(); p.ff_vy = rand_pos(); p.ff_turn_rate = rand_pos();
            p.meas_vx = rand_pos(); p.meas_vy = rand_pos();
        end
        else
        begin
            // Tracking near the goal keeps changes small, so clipping stays mixed.
            p.goal_x = POS_W'($urandom_range(0, 600000) - 300000);
            p.goal_y = POS_W'($urandom_range(0, 600000) - 300000);
            p.meas_x = POS_W'(p.goal_x + $urandom_range(0, 40000) - 20000);
            p.meas_y = POS_W'(p.goal_y + $urandom_range(0, 40000) - 20000);
            p.ff_vx = POS_W'($urandom_range(0, 100000) - 50000);
            p.ff_vy = POS_W'($urandom_range(0, 100000) - 50000);
            p.ff_turn_rate = POS_W'($urandom_range(0, 100000) - 50000);
            p.meas_vx = POS_W'(p.ff_vx + $urandom_range(0, 20000) - 10000);
            p.meas_vy = POS_W'(p.ff_vy + $urandom_range(0, 20000) - 10000);
        end
        return p;
    endfunction

    // Result side: stall pattern and comparison with the oldest expectation.
    always @(posedge clk)
    begin
        velocity_cmd_t e;
        if (rst_n)
        begin
            if (cmd_out.valid && cmd_out.ready)
            begin
                if (pend_wr == pend_rd)
                begin
                    $display("%0t: unexpected command vx=%0d vy=%0d", $realtime,
                             cmd_out.cmd_vx, cmd_out.cmd_vy);
                    error_count++;
                end
                else
                begin
                    e = pending_cmds[pend_rd % PEND_DEPTH];
                    pend_rd++;
                    if (cmd_out.cmd_vx !== e.cmd_vx || cmd_out.cmd_vy !== e.cmd_vy ||
                        cmd_out.cmd_turn_rate !== e.cmd_turn_rate ||
                        cmd_out.accel_clipped !== e.accel_clipped)
                    begin
                        $display("%0t: expected %0d %0d %0d %0b, actual %0d %0d %0d %0b",
                                 $realtime, e.cmd_vx, e.cmd_vy, e.cmd_turn_rate,
                                 e.accel_clipped, cmd_out.cmd_vx, cmd_out.cmd_vy,
                                 cmd_out.cmd_turn_rate, cmd_out.accel_clipped);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) rx_stall_on <= ~rx_stall_on;
            cmd_out.ready <= rx_stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
        else
            cmd_out.ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((pose_in.valid && pose_in.ready) || (cmd_out.valid && cmd_out.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    pose_item_t    vec_pose [VEC_ROWS];
    bit            vec_fixed [VEC_ROWS];
    velocity_cmd_t vec_cmd [VEC_ROWS];
    int            vec_count = 0;

    task automatic add_row(pose_item_t p, bit fixed, velocity_cmd_t c);
        vec_pose[vec_count] = p;
        vec_fixed[vec_count] = fixed;
        vec_cmd[vec_count] = c;
        vec_count++;
    endtask

    initial
    begin
        pose_item_t p;
        velocity_cmd_t c;
        int burst;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        pose_in.valid = 1'b0;
        {pose_in.meas_x, pose_in.meas_y, pose_in.meas_heading} = '0;
        {pose_in.goal_x, pose_in.goal_y, pose_in.goal_heading} = '0;
        {pose_in.ff_vx, pose_in.ff_vy, pose_in.ff_turn_rate} = '0;
        {pose_in.meas_vx, pose_in.meas_vy} = '0;
        load_defaults();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. An all-zero first item seeds the filter and gives zero.
        p = '{default: 0};
        c = '{cmd_vx: 0, cmd_vy: 0, cmd_turn_rate: 0, accel_clipped: 0};
        add_row(p, 1'b1, c);
        // Previous command all zero: feedforward only, no limit applied.
        p.ff_vx = 24'sh7FFFFF; p.ff_vy = -24'sh800000; p.ff_turn_rate = 24'sh7FFFFF;
        p.meas_vx = 24'sh7FFFFF; p.meas_vy = -24'sh800000;
        c = '{cmd_vx: 24'sh7FFFFF, cmd_vy: -24'sh800000, cmd_turn_rate: 24'sh7FFFFF,
              accel_clipped: 0};
        add_row(p, 1'b1, c);
        // Large change from a nonzero command triggers clipping.
        p = '{default: 0};
        add_row(p, 1'b0, c);
        // Heading errors past pi in both directions, and extreme positions.
        p.meas_heading = -205887; p.goal_heading = 205887;
        add_row(p, 1'b0, c);
        p.meas_heading = 205887; p.goal_heading = -205887;
        add_row(p, 1'b0, c);
        p.meas_x = 24'sh7FFFFF; p.goal_x = -24'sh800000;
        p.meas_y = -24'sh800000; p.goal_y = 24'sh7FFFFF;
        add_row(p, 1'b0, c);
        p.ff_vx = -24'sh800000; p.meas_vx = 24'sh7FFFFF;
        p.ff_vy = 24'sh7FFFFF; p.meas_vy = -24'sh800000;
        p.ff_turn_rate = -24'sh800000;
        add_row(p, 1'b0, c);
        for (int i = 0; i < 8; i++) add_row(rand_pose(1'b0), 1'b0, c);
        for (int i = 0; i < vec_count; i++)
            send_pose(vec_pose[i], vec_fixed[i], vec_cmd[i]);
        pose_in.valid <= 1'b0;
        wait_drained();

        // Register extremes: zero limit holds the planar command, full weight, etc.
        write_reg(CFG_ACCEL, 0);
        write_reg(CFG_WEIGHT, 65536);
        write_reg(CFG_POS_GAIN, 65535);
        write_reg(CFG_DAMP_GAIN, 0);
        write_reg(CFG_HEAD_GAIN, 65535);
        write_reg(CFG_PERIOD, 65535);
        for (int i = 0; i < 5; i++) send_pose(rand_pose(i[0]), 1'b0, c);
        pose_in.valid <= 1'b0;
        wait_drained();
        write_reg(CFG_ACCEL, 8388607);
        write_reg(CFG_WEIGHT, 131071);
        write_reg(CFG_POS_GAIN, 0);
        write_reg(CFG_DAMP_GAIN, 65535);
        write_reg(CFG_HEAD_GAIN, 0);
        write_reg(CFG_PERIOD, 1);
        for (int i = 0; i < 5; i++) send_pose(rand_pose(i[0]), 1'b0, c);
        pose_in.valid <= 1'b0;
        wait_drained();

        // Random part in phases, each with fresh settings, in bursts with gaps.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                write_reg(CFG_POS_GAIN, POS_GAIN_RST);
                write_reg(CFG_DAMP_GAIN, DAMP_GAIN_RST);
                write_reg(CFG_HEAD_GAIN, HEAD_GAIN_RST);
                write_reg(CFG_ACCEL, ACCEL_RST);
                write_reg(CFG_WEIGHT, WEIGHT_RST);
                write_reg(CFG_PERIOD, PERIOD_RST);
            end
            else
            begin
                write_reg(CFG_POS_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_DAMP_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_HEAD_GAIN, $urandom_range(0, 65535));
                write_reg(CFG_ACCEL, (ph % 3 == 0) ? $urandom_range(0, 8388607)
                                                    : $urandom_range(0, 400000));
                write_reg(CFG_WEIGHT, $urandom_range(0, 131071));
                write_reg(CFG_PERIOD, $urandom_range(1, 65535));
            end
            for (int n = 0; n < RANDOM_ITEMS / 8; )
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && n < RANDOM_ITEMS / 8; k++, n++)
                    send_pose(rand_pose($urandom_range(0, 4) == 0), 1'b0, c);
                pose_in.valid <= 1'b0;
                @(posedge clk);
                if ($urandom_range(0, 1))
                    repeat ($urandom_range(1, 150)) @(posedge clk);
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
